// File: hw/rtl/srdp_pkg.sv
// shared types, codes and reset values for the reactive drive policy
package srdp_pkg;

    // field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned RANGE_W = 16;
    localparam int unsigned SPEED_W = 8;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [RANGE_W-1:0] DETECT_THRESHOLD_RST = 16'd1000;
    localparam logic [RANGE_W-1:0] CLOSE_THRESHOLD_RST  = 16'd70;
    localparam logic [RANGE_W-1:0] ESCAPE_TIME_RST      = 16'd240;
    localparam logic [COUNT_W-1:0] DEBOUNCE_COUNT_RST   = 4'd2;
    localparam logic [SPEED_W-1:0] SPEED_FAST_RST       = 8'd255;
    localparam logic [SPEED_W-1:0] SPEED_TURN_RST       = 8'd200;
    localparam logic [SPEED_W-1:0] SPEED_ROTATE_RST     = 8'd175;
    localparam logic [SPEED_W-1:0] SPEED_ESCAPE_SLOW_RST = 8'd150;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETECT_THRESHOLD = 3'd0,
        CFG_CLOSE_THRESHOLD  = 3'd1,
        CFG_ESCAPE_TIME      = 3'd2,
        CFG_DEBOUNCE_COUNT   = 3'd3,
        CFG_SPEED_FAST       = 3'd4,
        CFG_SPEED_TURN       = 3'd5,
        CFG_SPEED_ROTATE     = 3'd6,
        CFG_SPEED_ESCAPE_SLOW = 3'd7
    } cfg_idx_t;

    // drive command codes
    typedef enum logic [2:0] {
        ACT_FORWARD   = 3'd0,
        ACT_ROT_LEFT  = 3'd1,
        ACT_ROT_RIGHT = 3'd2,
        ACT_DIFF      = 3'd3,
        ACT_NONE      = 3'd4
    } action_t;

    // escape manoeuvre shapes
    typedef enum logic [1:0] {
        ESC_STRAIGHT    = 2'd0,
        ESC_CURVE_LEFT  = 2'd1,
        ESC_CURVE_RIGHT = 2'd2
    } esc_mode_t;

    // side a target was last seen on
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    // one tick word
    typedef struct packed {
        logic [TIME_W-1:0]  now_ms;
        logic               line_left;
        logic               line_right;
        logic [RANGE_W-1:0] front_center_mm;
        logic [RANGE_W-1:0] front_left_mm;
        logic [RANGE_W-1:0] front_right_mm;
        logic [RANGE_W-1:0] side_left_mm;
        logic [RANGE_W-1:0] side_right_mm;
    } tick_t;

    // one command word
    typedef struct packed {
        action_t            action;
        logic [SPEED_W-1:0] left_speed;
        logic [SPEED_W-1:0] right_speed;
        logic               escaping;
    } cmd_t;

    // settings used by the line tracker
    typedef struct packed {
        logic [RANGE_W-1:0] escape_time_ms;
        logic [COUNT_W-1:0] debounce_count;
    } line_cfg_t;

    // escape status from the line tracker
    typedef struct packed {
        logic      active;
        esc_mode_t mode;
    } esc_status_t;

endpackage

// File: hw/rtl/srdp_if.sv
// handshake channels for tick words, command words and configuration writes
interface srdp_tick_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        line_left;
    logic        line_right;
    logic [15:0] front_center_mm;
    logic [15:0] front_left_mm;
    logic [15:0] front_right_mm;
    logic [15:0] side_left_mm;
    logic [15:0] side_right_mm;

    modport source (
        output valid, now_ms, line_left, line_right, front_center_mm,
               front_left_mm, front_right_mm, side_left_mm, side_right_mm,
        input  ready
    );
    modport sink (
        input  valid, now_ms, line_left, line_right, front_center_mm,
               front_left_mm, front_right_mm, side_left_mm, side_right_mm,
        output ready
    );
endinterface

interface srdp_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic       escaping;

    modport source (
        output valid, action, left_speed, right_speed, escaping,
        input  ready
    );
    modport sink (
        input  valid, action, left_speed, right_speed, escaping,
        output ready
    );
endinterface

interface srdp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: hw/rtl/sumo_robot_reactive_drive_policy.sv
// top level of the reactive drive policy: input register, decision logic, command register
// a tick word enters the input register, then its command word the command register
// throughput: one word per cycle while cmd.ready holds; the single decision pass sets this
// the command register frees while its word is taken, so it refills as its word leaves
// reset: configuration returns to its defaults, streaks clear, both lines armed,
// no escape pending, last side right, both pipeline stages empty
module sumo_robot_reactive_drive_policy (
    input  logic         clk,
    input  logic         rst_n,
    srdp_tick_if.sink    tick,
    srdp_cmd_if.source   cmd,
    srdp_cfg_if.sink     cfg
);
    import srdp_pkg::*;

    // configuration registers
    logic [RANGE_W-1:0] detect_threshold_reg, close_threshold_reg, escape_time_reg;
    logic [COUNT_W-1:0] debounce_count_reg;
    logic [SPEED_W-1:0] speed_fast_reg, speed_turn_reg, speed_rotate_reg;
    logic [SPEED_W-1:0] speed_escape_slow_reg;

    // pipeline
    logic        s1_valid_reg;
    tick_t       s1_item_reg;
    logic        out_valid_reg;
    cmd_t        out_item_reg, out_item_next;
    logic        out_free, adv;

    // decision signals
    logic        last_side_reg, last_side_next;
    logic        tc, tl, tr, tsl, tsr;
    line_cfg_t   line_cfg;
    esc_status_t esc;

    // configuration writes, always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_threshold_reg  <= DETECT_THRESHOLD_RST;
            close_threshold_reg   <= CLOSE_THRESHOLD_RST;
            escape_time_reg       <= ESCAPE_TIME_RST;
            debounce_count_reg    <= DEBOUNCE_COUNT_RST;
            speed_fast_reg        <= SPEED_FAST_RST;
            speed_turn_reg        <= SPEED_TURN_RST;
            speed_rotate_reg      <= SPEED_ROTATE_RST;
            speed_escape_slow_reg <= SPEED_ESCAPE_SLOW_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_DETECT_THRESHOLD:  detect_threshold_reg  <= cfg.data;
                CFG_CLOSE_THRESHOLD:   close_threshold_reg   <= cfg.data;
                CFG_ESCAPE_TIME:       escape_time_reg       <= cfg.data;
                CFG_DEBOUNCE_COUNT:    debounce_count_reg    <= cfg.data[COUNT_W-1:0];
                CFG_SPEED_FAST:        speed_fast_reg        <= cfg.data[SPEED_W-1:0];
                CFG_SPEED_TURN:        speed_turn_reg        <= cfg.data[SPEED_W-1:0];
                CFG_SPEED_ROTATE:      speed_rotate_reg      <= cfg.data[SPEED_W-1:0];
                CFG_SPEED_ESCAPE_SLOW: speed_escape_slow_reg <= cfg.data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: the input stage refills whenever its word moves on
    assign out_free   = !out_valid_reg || cmd.ready;
    assign adv        = s1_valid_reg && out_free;
    assign tick.ready = !s1_valid_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (tick.ready)
            s1_valid_reg <= tick.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            s1_item_reg.now_ms          <= tick.now_ms;
            s1_item_reg.line_left       <= tick.line_left;
            s1_item_reg.line_right      <= tick.line_right;
            s1_item_reg.front_center_mm <= tick.front_center_mm;
            s1_item_reg.front_left_mm   <= tick.front_left_mm;
            s1_item_reg.front_right_mm  <= tick.front_right_mm;
            s1_item_reg.side_left_mm    <= tick.side_left_mm;
            s1_item_reg.side_right_mm   <= tick.side_right_mm;
        end
    end

    // edge line tracker
    assign line_cfg.escape_time_ms = escape_time_reg;
    assign line_cfg.debounce_count = debounce_count_reg;

    srdp_line u_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .now_ms     (s1_item_reg.now_ms),
        .line_left  (s1_item_reg.line_left),
        .line_right (s1_item_reg.line_right),
        .cfg        (line_cfg),
        .status     (esc)
    );

    // target flags
    always_comb
    begin
        tc  = s1_item_reg.front_center_mm < detect_threshold_reg;
        tl  = s1_item_reg.front_left_mm   < detect_threshold_reg;
        tr  = s1_item_reg.front_right_mm  < detect_threshold_reg;
        tsl = s1_item_reg.side_left_mm    < detect_threshold_reg;
        tsr = s1_item_reg.side_right_mm   < detect_threshold_reg;
    end

    // last seen side, held while escaping
    always_comb
    begin
        last_side_next = last_side_reg;
        if (!esc.active)
        begin
            if (tsl && !tsr)
                last_side_next = SIDE_LEFT;
            else if (tsr && !tsl)
                last_side_next = SIDE_RIGHT;
            else if (tl && !tr)
                last_side_next = SIDE_LEFT;
            else if (tr && !tl)
                last_side_next = SIDE_RIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_side_reg <= SIDE_RIGHT;
        else if (adv)
            last_side_reg <= last_side_next;
    end

    // command selection
    always_comb
    begin
        out_item_next.escaping    = esc.active;
        out_item_next.action      = ACT_NONE;
        out_item_next.left_speed  = '0;
        out_item_next.right_speed = '0;
        if (esc.active)
        begin
            case (esc.mode)
                ESC_CURVE_LEFT:
                begin
                    out_item_next.action      = ACT_DIFF;
                    out_item_next.left_speed  = speed_escape_slow_reg;
                    out_item_next.right_speed = speed_fast_reg;
                end
                ESC_CURVE_RIGHT:
                begin
                    out_item_next.action      = ACT_DIFF;
                    out_item_next.left_speed  = speed_fast_reg;
                    out_item_next.right_speed = speed_escape_slow_reg;
                end
                default:
                begin
                    out_item_next.action      = ACT_FORWARD;
                    out_item_next.left_speed  = speed_fast_reg;
                    out_item_next.right_speed = speed_fast_reg;
                end
            endcase
        end
        else if (!(tc || tl || tr || tsl || tsr))
        begin
            // search by spinning right
            out_item_next.action      = ACT_ROT_RIGHT;
            out_item_next.left_speed  = speed_rotate_reg;
            out_item_next.right_speed = speed_rotate_reg;
        end
        else if (tc || (tl && tr))
        begin
            out_item_next.action      = ACT_FORWARD;
            out_item_next.left_speed  = speed_fast_reg;
            out_item_next.right_speed = speed_fast_reg;
        end
        else if (tl)
        begin
            if (s1_item_reg.front_left_mm <= close_threshold_reg)
            begin
                out_item_next.action      = ACT_ROT_LEFT;
                out_item_next.left_speed  = speed_rotate_reg;
                out_item_next.right_speed = speed_rotate_reg;
            end
            else
            begin
                out_item_next.action      = ACT_DIFF;
                out_item_next.left_speed  = speed_turn_reg;
                out_item_next.right_speed = speed_fast_reg;
            end
        end
        else if (tr)
        begin
            if (s1_item_reg.front_right_mm <= close_threshold_reg)
            begin
                out_item_next.action      = ACT_ROT_RIGHT;
                out_item_next.left_speed  = speed_rotate_reg;
                out_item_next.right_speed = speed_rotate_reg;
            end
            else
            begin
                out_item_next.action      = ACT_DIFF;
                out_item_next.left_speed  = speed_fast_reg;
                out_item_next.right_speed = speed_turn_reg;
            end
        end
        else if (tsl && tsr)
        begin
            out_item_next.action      = (last_side_next == SIDE_LEFT) ? ACT_ROT_LEFT
                                                                      : ACT_ROT_RIGHT;
            out_item_next.left_speed  = speed_rotate_reg;
            out_item_next.right_speed = speed_rotate_reg;
        end
    end

    // command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_item_reg <= out_item_next;
    end

    assign cmd.valid       = out_valid_reg;
    assign cmd.action      = out_item_reg.action;
    assign cmd.left_speed  = out_item_reg.left_speed;
    assign cmd.right_speed = out_item_reg.right_speed;
    assign cmd.escaping    = out_item_reg.escaping;

    // an escape command only drives forward or differentially
    a_escape_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.escaping) |->
            (cmd.action == ACT_FORWARD || cmd.action == ACT_DIFF))
        else $error("escape command with a rotate or idle action");

    // no command carries zero speeds and is never an escape
    a_none_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.action == ACT_NONE) |->
            (cmd.left_speed == '0 && cmd.right_speed == '0 && !cmd.escaping))
        else $error("no-command word with non-zero speed or escape flag");

    // an accepted tick word is held in the input stage on the next cycle
    a_tick_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (tick.valid && tick.ready) |=> s1_valid_reg)
        else $error("accepted tick word lost");

    // a word leaving the input stage always lands in the command register
    a_word_moves: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("decided command word dropped");

endmodule

// File: hw/rtl/srdp_line.sv
// edge line debounce and timed escape tracker
module srdp_line (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic [srdp_pkg::TIME_W-1:0] now_ms,
    input  logic                       line_left,
    input  logic                       line_right,
    input  srdp_pkg::line_cfg_t        cfg,
    output srdp_pkg::esc_status_t      status
);
    import srdp_pkg::*;

    logic [COUNT_W-1:0] left_streak_reg, left_streak_next;
    logic [COUNT_W-1:0] right_streak_reg, right_streak_next;
    logic               left_armed_reg, right_armed_reg;
    esc_mode_t          mode_reg, mode_next;
    logic [TIME_W-1:0]  deadline_reg, deadline_next;
    logic               left_deb, right_deb, start;
    logic [TIME_W-1:0]  remain;

    // saturating streak counters
    always_comb
    begin
        if (!line_left)
            left_streak_next = '0;
        else if (left_streak_reg < cfg.debounce_count)
            left_streak_next = left_streak_reg + COUNT_W'(1);
        else
            left_streak_next = left_streak_reg;

        if (!line_right)
            right_streak_next = '0;
        else if (right_streak_reg < cfg.debounce_count)
            right_streak_next = right_streak_reg + COUNT_W'(1);
        else
            right_streak_next = right_streak_reg;
    end

    assign left_deb  = left_streak_next >= cfg.debounce_count;
    assign right_deb = right_streak_next >= cfg.debounce_count;
    assign start     = (left_deb && left_armed_reg) || (right_deb && right_armed_reg);

    // new escape shape and deadline
    always_comb
    begin
        if (left_deb && right_deb)
            mode_next = ESC_STRAIGHT;
        else if (left_deb)
            mode_next = ESC_CURVE_RIGHT;
        else
            mode_next = ESC_CURVE_LEFT;
        deadline_next = now_ms + TIME_W'(cfg.escape_time_ms);
    end

    // time left on the escape; a fresh escape has exactly its duration left
    assign remain = start ? TIME_W'(cfg.escape_time_ms) : (deadline_reg - now_ms);

    always_comb
    begin
        status.active = (remain != '0) && !remain[TIME_W-1];
        status.mode   = start ? mode_next : mode_reg;
    end

    // tracker state, moves once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_streak_reg  <= '0;
            right_streak_reg <= '0;
            left_armed_reg   <= 1'b1;
            right_armed_reg  <= 1'b1;
            mode_reg         <= ESC_STRAIGHT;
            deadline_reg     <= '0;
        end
        else if (adv)
        begin
            left_streak_reg  <= left_streak_next;
            right_streak_reg <= right_streak_next;
            left_armed_reg   <= !left_deb;
            right_armed_reg  <= !right_deb;
            if (start)
            begin
                mode_reg     <= mode_next;
                deadline_reg <= deadline_next;
            end
        end
    end

endmodule
